// ----- src/ltb_pkg.sv -----
// Package for the laser point to base transform: pipeline stage map,
// fixed-point constants, register indexes and shared types. No dependencies.
`default_nettype none
package ltb_pkg;

    // pipeline stage numbers
    localparam int ST_IN    = 0;
    localparam int ST_RED   = 1;
    localparam int ST_QUAD  = 2;
    localparam int ST_RAD   = 3;
    localparam int ST_SQ    = 4;
    localparam int ST_DIV0  = 5;
    localparam int ST_DIV1  = 6;
    localparam int ST_HORN  = 7;
    localparam int N_HORN   = 6;
    localparam int ST_MULX  = ST_HORN + N_HORN;
    localparam int ST_SEL   = ST_MULX + 1;
    localparam int ST_PROD2 = ST_SEL + 1;
    localparam int ST_PROD3 = ST_PROD2 + 1;
    localparam int ST_MAT   = ST_PROD3 + 1;
    localparam int ST_ROW   = ST_MAT + 1;
    localparam int ST_SUM   = ST_ROW + 1;
    localparam int ST_OUT   = ST_SUM + 1;
    localparam int NUM_STAGES = ST_OUT + 1;
    localparam int ST_HE_MUL = 1;
    localparam int ST_HE_SUM = 2;

    // angles, Q16 degrees
    localparam logic [24:0] DEG_FULL = 25'd23592960;
    localparam logic [22:0] DEG_QUAD = 23'd5898240;
    localparam logic [24:0] RAD_PER_DEG = 25'd18740330;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    localparam logic [7:0] HORNER_DIV [N_HORN] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] HORNER_RECIP [N_HORN] = '{
        32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)};

    // hand-eye rotation, Q2.16, columns X and Z
    localparam logic signed [17:0] HAND_ROT [3][2] = '{
        '{18'sd5892, -18'sd50482},
        '{18'sd64448, 18'sd1750},
        '{18'sd4594, 18'sd35861}};

    localparam logic signed [31:0] LASER_OFFSET_RST [3] = '{
        32'sd3076758, -32'sd127428, 32'sd23021689};

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LASER_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LASER_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LASER_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_Z   = 3'd5;

    localparam int FL_W  = 35;
    localparam int ACC_W = 43;

    typedef logic [NUM_STAGES-1:0] t_en;

    typedef struct packed {
        logic signed [18:0] s;
        logic signed [18:0] c;
    } t_sc;

endpackage
`default_nettype wire

// ----- src/ltb_in_if.sv -----
// Input beat channel: one laser point and flange pose.
// Depends on nothing.
`default_nettype none
interface ltb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] laser_x;
    logic signed [31:0] laser_z;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_z;
    logic signed [25:0] pose_rz;
    logic signed [25:0] pose_ry;
    logic signed [25:0] pose_rx;

    modport source (output valid, laser_x, laser_z, pose_x, pose_y, pose_z,
                    pose_rz, pose_ry, pose_rx, input ready);
    modport sink   (input valid, laser_x, laser_z, pose_x, pose_y, pose_z,
                    pose_rz, pose_ry, pose_rx, output ready);
endinterface
`default_nettype wire

// ----- src/ltb_out_if.sv -----
// Result beat channel: point in the robot base frame.
// Depends on nothing.
`default_nettype none
interface ltb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;

    modport source (output valid, base_x, base_y, base_z, input ready);
    modport sink   (input valid, base_x, base_y, base_z, output ready);
endinterface
`default_nettype wire

// ----- src/ltb_cfg_if.sv -----
// Configuration write channel: register index and data.
// Depends on nothing.
`default_nettype none
interface ltb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/ltb_sinq.sv -----
// Pipelined quarter-wave sine: radian conversion, Taylor series in Horner form.
// Depends on ltb_pkg.
`default_nettype none
module ltb_sinq (
    input  wire logic          i_clk,
    input  wire ltb_pkg::t_en  i_en,
    input  wire logic [22:0]   i_r,
    output logic [30:0]        o_t
);
    logic [30:0] r_x [ltb_pkg::ST_RAD:ltb_pkg::ST_MULX-1];
    logic [31:0] r_x2;
    logic [31:0] r_x2d;
    logic [31:0] r_q0 [ltb_pkg::N_HORN];
    logic [31:0] r_dv [ltb_pkg::N_HORN][ltb_pkg::N_HORN];
    logic [30:0] r_t  [ltb_pkg::N_HORN];
    logic [30:0] r_tf;

    logic [47:0] n_xp;
    logic [61:0] n_x2p;
    logic [63:0] n_qp [ltb_pkg::N_HORN];
    logic [32:0] n_rem [ltb_pkg::N_HORN];
    logic [31:0] n_dv [ltb_pkg::N_HORN];
    logic [62:0] n_hp [ltb_pkg::N_HORN];
    logic [30:0] n_t [ltb_pkg::N_HORN];
    logic [61:0] n_fp;

    always_comb begin
        n_xp  = 48'(i_r) * 48'(ltb_pkg::RAD_PER_DEG) + 48'h8000;
        n_x2p = 62'(r_x[ltb_pkg::ST_RAD]) * 62'(r_x[ltb_pkg::ST_RAD]) + (62'd1 << 29);
        for (int i = 0; i < ltb_pkg::N_HORN; i++) begin
            n_qp[i]  = 64'(r_x2) * 64'(ltb_pkg::HORNER_RECIP[i]);
            n_rem[i] = 33'(r_x2d) - 33'(r_q0[i]) * 33'(ltb_pkg::HORNER_DIV[i]);
            n_dv[i]  = (n_rem[i] >= 33'(ltb_pkg::HORNER_DIV[i])) ? r_q0[i] + 32'd1 : r_q0[i];
            n_hp[i]  = 63'(r_dv[i][i]) * 63'((i == 0) ? ltb_pkg::Q30_ONE : r_t[(i == 0) ? 0 : i-1])
                     + (63'd1 << 29);
            n_t[i]   = 31'(34'(ltb_pkg::Q30_ONE) - 34'(n_hp[i][62:30]));
        end
        n_fp = 62'(r_x[ltb_pkg::ST_MULX-1]) * 62'(r_t[ltb_pkg::N_HORN-1]) + (62'd1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ltb_pkg::ST_RAD]) r_x[ltb_pkg::ST_RAD] <= n_xp[46:16];
        for (int k = ltb_pkg::ST_RAD + 1; k < ltb_pkg::ST_MULX; k++) begin
            if (i_en[k]) r_x[k] <= r_x[k-1];
        end
        if (i_en[ltb_pkg::ST_SQ]) r_x2 <= n_x2p[61:30];
        if (i_en[ltb_pkg::ST_DIV0]) begin
            r_x2d <= r_x2;
            for (int i = 0; i < ltb_pkg::N_HORN; i++) r_q0[i] <= n_qp[i][63:32];
        end
        if (i_en[ltb_pkg::ST_DIV1]) r_dv[0] <= n_dv;
        for (int j = 0; j < ltb_pkg::N_HORN; j++) begin
            if (i_en[ltb_pkg::ST_HORN + j]) begin
                r_t[j] <= n_t[j];
                if (j < ltb_pkg::N_HORN - 1) r_dv[(j < ltb_pkg::N_HORN - 1) ? j+1 : j] <= r_dv[j];
            end
        end
        if (i_en[ltb_pkg::ST_MULX]) r_tf <= n_fp[60:30];
    end

    assign o_t = r_tf;
endmodule
`default_nettype wire

// ----- src/ltb_sincos.sv -----
// Sine and cosine of one pose angle: modulo-360 reduction, quadrant fold,
// two quarter-wave units. Depends on ltb_pkg and ltb_sinq.
`default_nettype none
module ltb_sincos (
    input  wire logic               i_clk,
    input  wire ltb_pkg::t_en       i_en,
    input  wire logic signed [25:0] i_ang,
    output ltb_pkg::t_sc            o_sc
);
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam logic signed [26:0] FULL = 27'(ltb_pkg::DEG_FULL);
    localparam logic [24:0] Q1 = 25'(ltb_pkg::DEG_QUAD);
    localparam logic [24:0] Q2 = 25'(ltb_pkg::DEG_QUAD) * 25'd2;
    localparam logic [24:0] Q3 = 25'(ltb_pkg::DEG_QUAD) * 25'd3;

    logic signed [26:0] n_a;
    logic signed [26:0] n_m;
    logic [24:0] r_m;
    logic [1:0]  n_q;
    logic [24:0] n_r;
    logic [22:0] r_r, r_rc;
    logic [1:0]  r_q [ltb_pkg::ST_QUAD:ltb_pkg::ST_MULX];
    logic [30:0] w_ts, w_tc;
    logic [31:0] n_sr, n_cr;
    logic signed [18:0] n_s, n_c, w_sr, w_cr;
    ltb_pkg::t_sc r_sc;

    always_comb begin
        n_a = 27'(i_ang);
        if (n_a < -FULL)      n_m = n_a + FULL + FULL;
        else if (n_a < 27'sd0) n_m = n_a + FULL;
        else if (n_a >= FULL) n_m = n_a - FULL;
        else                  n_m = n_a;

        if (r_m >= Q3) begin
            n_q = QUAD_3; n_r = r_m - Q3;
        end else if (r_m >= Q2) begin
            n_q = QUAD_2; n_r = r_m - Q2;
        end else if (r_m >= Q1) begin
            n_q = QUAD_1; n_r = r_m - Q1;
        end else begin
            n_q = QUAD_0; n_r = r_m;
        end

        n_sr = 32'(w_ts) + 32'h2000;
        n_cr = 32'(w_tc) + 32'h2000;
        w_sr = {1'b0, n_sr[31:14]};
        w_cr = {1'b0, n_cr[31:14]};
        case (r_q[ltb_pkg::ST_MULX])
            QUAD_0: begin n_s = w_sr;  n_c = w_cr;  end
            QUAD_1: begin n_s = w_cr;  n_c = -w_sr; end
            QUAD_2: begin n_s = -w_sr; n_c = -w_cr; end
            QUAD_3: begin n_s = -w_cr; n_c = w_sr;  end
            default: begin n_s = w_sr; n_c = w_cr;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ltb_pkg::ST_RED]) r_m <= n_m[24:0];
        if (i_en[ltb_pkg::ST_QUAD]) begin
            r_q[ltb_pkg::ST_QUAD] <= n_q;
            r_r  <= n_r[22:0];
            r_rc <= ltb_pkg::DEG_QUAD - n_r[22:0];
        end
        for (int k = ltb_pkg::ST_QUAD + 1; k <= ltb_pkg::ST_MULX; k++) begin
            if (i_en[k]) r_q[k] <= r_q[k-1];
        end
        if (i_en[ltb_pkg::ST_SEL]) begin
            r_sc.s <= n_s;
            r_sc.c <= n_c;
        end
    end

    ltb_sinq u_sin (.i_clk(i_clk), .i_en(i_en), .i_r(r_r),  .o_t(w_ts));
    ltb_sinq u_cos (.i_clk(i_clk), .i_en(i_en), .i_r(r_rc), .o_t(w_tc));

    assign o_sc = r_sc;
endmodule
`default_nettype wire

// ----- src/ltb_rot.sv -----
// Pose rotation: builds the matrix from sines and cosines and forms the three
// rounded row sums against the flange point. Depends on ltb_pkg.
`default_nettype none
module ltb_rot (
    input  wire logic                              i_clk,
    input  wire ltb_pkg::t_en                      i_en,
    input  wire ltb_pkg::t_sc                      i_a,
    input  wire ltb_pkg::t_sc                      i_b,
    input  wire ltb_pkg::t_sc                      i_c,
    input  wire logic signed [ltb_pkg::FL_W-1:0]   i_fl [3],
    output logic signed [ltb_pkg::ACC_W-1:0]       o_acc [3]
);
    // two-factor products, Q32
    logic signed [37:0] r_cacb, r_sacb, r_cbsc, r_cbcc, r_casb, r_sasb;
    logic signed [37:0] r_sacc, r_sasc, r_cacc, r_casc, r_sacc2, r_sasc2, r_cacc2, r_casc2;
    logic signed [18:0] r_sc1, r_cc1, r_sb1;
    // three-factor products, Q48
    logic signed [56:0] r_t01, r_t02, r_t11, r_t12;
    logic signed [21:0] r_m00a, r_m10a, r_m21a, r_m22a, r_m20a;
    logic signed [21:0] r_m [3][3];
    logic signed [56:0] r_mp [3][3];
    logic signed [ltb_pkg::ACC_W-1:0] r_acc [3];

    logic signed [57:0] n_m01, n_m02, n_m11, n_m12;
    logic signed [37:0] n_r00, n_r10, n_r21, n_r22;
    logic signed [58:0] n_sum [3];

    function automatic logic signed [57:0] f_tri(input logic signed [56:0] t,
                                                 input logic signed [37:0] p,
                                                 input logic neg);
        logic signed [57:0] w;
        begin
            w = neg ? 58'(t) - (58'(p) <<< 16) : 58'(t) + (58'(p) <<< 16);
            f_tri = (w + (58'sd1 <<< 31)) >>> 32;
        end
    endfunction

    always_comb begin
        n_r00 = (r_cacb + 38'sd32768) >>> 16;
        n_r10 = (r_sacb + 38'sd32768) >>> 16;
        n_r21 = (r_cbsc + 38'sd32768) >>> 16;
        n_r22 = (r_cbcc + 38'sd32768) >>> 16;
        n_m01 = f_tri(r_t01, r_sacc2, 1'b1);
        n_m02 = f_tri(r_t02, r_sasc2, 1'b0);
        n_m11 = f_tri(r_t11, r_cacc2, 1'b0);
        n_m12 = f_tri(r_t12, r_casc2, 1'b1);
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = 59'(r_mp[i][0]) + 59'(r_mp[i][1]) + 59'(r_mp[i][2]) + 59'sd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ltb_pkg::ST_PROD2]) begin
            r_cacb <= 38'(i_a.c) * 38'(i_b.c);
            r_sacb <= 38'(i_a.s) * 38'(i_b.c);
            r_cbsc <= 38'(i_b.c) * 38'(i_c.s);
            r_cbcc <= 38'(i_b.c) * 38'(i_c.c);
            r_casb <= 38'(i_a.c) * 38'(i_b.s);
            r_sasb <= 38'(i_a.s) * 38'(i_b.s);
            r_sacc <= 38'(i_a.s) * 38'(i_c.c);
            r_sasc <= 38'(i_a.s) * 38'(i_c.s);
            r_cacc <= 38'(i_a.c) * 38'(i_c.c);
            r_casc <= 38'(i_a.c) * 38'(i_c.s);
            r_sc1  <= i_c.s;
            r_cc1  <= i_c.c;
            r_sb1  <= i_b.s;
        end
        if (i_en[ltb_pkg::ST_PROD3]) begin
            r_t01 <= 57'(r_casb) * 57'(r_sc1);
            r_t02 <= 57'(r_casb) * 57'(r_cc1);
            r_t11 <= 57'(r_sasb) * 57'(r_sc1);
            r_t12 <= 57'(r_sasb) * 57'(r_cc1);
            r_sacc2 <= r_sacc;
            r_sasc2 <= r_sasc;
            r_cacc2 <= r_cacc;
            r_casc2 <= r_casc;
            r_m00a <= 22'(n_r00);
            r_m10a <= 22'(n_r10);
            r_m21a <= 22'(n_r21);
            r_m22a <= 22'(n_r22);
            r_m20a <= -22'(r_sb1);
        end
        if (i_en[ltb_pkg::ST_MAT]) begin
            r_m[0][0] <= r_m00a;
            r_m[0][1] <= 22'(n_m01);
            r_m[0][2] <= 22'(n_m02);
            r_m[1][0] <= r_m10a;
            r_m[1][1] <= 22'(n_m11);
            r_m[1][2] <= 22'(n_m12);
            r_m[2][0] <= r_m20a;
            r_m[2][1] <= r_m21a;
            r_m[2][2] <= r_m22a;
        end
        if (i_en[ltb_pkg::ST_ROW]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mp[i][j] <= 57'(r_m[i][j]) * 57'(i_fl[j]);
                end
            end
        end
        if (i_en[ltb_pkg::ST_SUM]) begin
            for (int i = 0; i < 3; i++) r_acc[i] <= ltb_pkg::ACC_W'(n_sum[i] >>> 16);
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ----- src/laser_point_to_base_transform_unit.sv -----
// Top level of the laser point to base transform: channels, registers,
// hand-eye stage, delay lines and output saturation.
// Depends on ltb_pkg, the ltb_*_if interfaces, ltb_sincos and ltb_rot.
//
//  channel | dir | beat contents
//  i_in    | in  | laser_x, laser_z, pose_x/y/z, pose_rz/ry/rx
//  o_out   | out | base_x, base_y, base_z
//  i_cfg   | in  | index 0..5, data (32-bit register value)
//
// One beat per cycle while the output is not stalled.
// 21 register stages, each with its own valid; a stage loads when it is empty
// or the stage after it moves, so bubbles close up under output stalls.
// Synchronous active-low reset clears valids and loads register reset values;
// input and configuration ready stay low while reset is held.
// Configuration writes are taken whenever out of reset; index 6 or 7 is dropped.
`default_nettype none
module laser_point_to_base_transform_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ltb_in_if.sink     i_in,
    ltb_out_if.source  o_out,
    ltb_cfg_if.sink    i_cfg
);
    localparam int LAST = ltb_pkg::ST_OUT;

    ltb_pkg::t_en r_vld;
    ltb_pkg::t_en n_en;

    logic signed [31:0] r_off [3];
    logic signed [31:0] r_corr [3];

    logic signed [31:0] r_lx, r_lz;
    logic signed [25:0] r_rz, r_ry, r_rx;
    logic signed [31:0] r_pos [ltb_pkg::ST_IN:ltb_pkg::ST_SUM][3];
    logic signed [48:0] r_hp [3][2];
    logic signed [ltb_pkg::FL_W-1:0] r_fl [ltb_pkg::ST_HE_SUM:ltb_pkg::ST_MAT][3];
    logic signed [ltb_pkg::FL_W-1:0] n_fl [3];
    logic signed [49:0] n_hs [3];
    logic signed [44:0] n_res [3];
    logic signed [31:0] r_out [3];

    ltb_pkg::t_sc w_sa, w_sb, w_sc;
    logic signed [ltb_pkg::ACC_W-1:0] w_acc [3];

    always_comb begin
        n_en[LAST] = !r_vld[LAST] || o_out.ready;
        for (int k = LAST - 1; k >= 0; k--) n_en[k] = !r_vld[k] || n_en[k+1];
        for (int i = 0; i < 3; i++) begin
            n_hs[i] = 50'(r_hp[i][0]) + 50'(r_hp[i][1]) + 50'sd32768;
            n_fl[i] = ltb_pkg::FL_W'(n_hs[i] >>> 16) + ltb_pkg::FL_W'(r_off[i]);
            n_res[i] = 45'(w_acc[i]) + 45'(r_pos[ltb_pkg::ST_SUM][i]) + 45'(r_corr[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int i = 0; i < 3; i++) begin
                r_off[i]  <= ltb_pkg::LASER_OFFSET_RST[i];
                r_corr[i] <= '0;
            end
        end else begin
            for (int k = 0; k <= LAST; k++) begin
                if (n_en[k]) r_vld[k] <= (k == 0) ? i_in.valid : r_vld[(k == 0) ? 0 : k-1];
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    ltb_pkg::CFG_LASER_OFFSET_X: r_off[0]  <= i_cfg.data;
                    ltb_pkg::CFG_LASER_OFFSET_Y: r_off[1]  <= i_cfg.data;
                    ltb_pkg::CFG_LASER_OFFSET_Z: r_off[2]  <= i_cfg.data;
                    ltb_pkg::CFG_CORRECTION_X:   r_corr[0] <= i_cfg.data;
                    ltb_pkg::CFG_CORRECTION_Y:   r_corr[1] <= i_cfg.data;
                    ltb_pkg::CFG_CORRECTION_Z:   r_corr[2] <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[ltb_pkg::ST_IN]) begin
            r_lx <= i_in.laser_x;
            r_lz <= i_in.laser_z;
            r_rz <= i_in.pose_rz;
            r_ry <= i_in.pose_ry;
            r_rx <= i_in.pose_rx;
            r_pos[ltb_pkg::ST_IN][0] <= i_in.pose_x;
            r_pos[ltb_pkg::ST_IN][1] <= i_in.pose_y;
            r_pos[ltb_pkg::ST_IN][2] <= i_in.pose_z;
        end
        for (int k = ltb_pkg::ST_IN + 1; k <= ltb_pkg::ST_SUM; k++) begin
            if (n_en[k]) r_pos[k] <= r_pos[k-1];
        end
        if (n_en[ltb_pkg::ST_HE_MUL]) begin
            for (int i = 0; i < 3; i++) begin
                r_hp[i][0] <= 49'(ltb_pkg::HAND_ROT[i][0]) * 49'(r_lx);
                r_hp[i][1] <= 49'(ltb_pkg::HAND_ROT[i][1]) * 49'(r_lz);
            end
        end
        if (n_en[ltb_pkg::ST_HE_SUM]) r_fl[ltb_pkg::ST_HE_SUM] <= n_fl;
        for (int k = ltb_pkg::ST_HE_SUM + 1; k <= ltb_pkg::ST_MAT; k++) begin
            if (n_en[k]) r_fl[k] <= r_fl[k-1];
        end
        if (n_en[LAST]) begin
            for (int i = 0; i < 3; i++) begin
                if (n_res[i] > 45'sd2147483647)       r_out[i] <= 32'h7FFF_FFFF;
                else if (n_res[i] < -45'sd2147483648) r_out[i] <= 32'h8000_0000;
                else                                  r_out[i] <= n_res[i][31:0];
            end
        end
    end

    ltb_sincos u_ang_a (.i_clk(i_clk), .i_en(n_en), .i_ang(r_rx), .o_sc(w_sa));
    ltb_sincos u_ang_b (.i_clk(i_clk), .i_en(n_en), .i_ang(r_ry), .o_sc(w_sb));
    ltb_sincos u_ang_c (.i_clk(i_clk), .i_en(n_en), .i_ang(r_rz), .o_sc(w_sc));

    ltb_rot u_rot (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (w_sa),
        .i_b   (w_sb),
        .i_c   (w_sc),
        .i_fl  (r_fl[ltb_pkg::ST_MAT]),
        .o_acc (w_acc)
    );

    assign i_in.ready   = n_en[ltb_pkg::ST_IN] && i_rst_n;
    assign i_cfg.ready  = i_rst_n;
    assign o_out.valid  = r_vld[LAST];
    assign o_out.base_x = r_out[0];
    assign o_out.base_y = r_out[1];
    assign o_out.base_z = r_out[2];
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for laser_point_to_base_transform_unit: directed and random beats
// checked against a local fixed-point model of the pose transform.
// Depends on ltb_pkg and the ltb_in_if, ltb_out_if and ltb_cfg_if interfaces.
`timescale 1ns / 100ps
module testbench;

    localparam logic [ltb_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [ltb_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int  PIPE_LAT    = 21;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint ANG_FULL = 23592960;
    localparam longint ANG_QUAD = 5898240;

    typedef struct {
        logic signed [31:0] lx, lz, px, py, pz;
        logic signed [25:0] rz, ry, rx;
    } t_point_pose;

    typedef struct {
        logic signed [31:0] bx, by, bz;
    } t_base_pt;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ltb_in_if  in_ch();
    ltb_out_if out_ch();
    ltb_cfg_if cfg_ch();

    laser_point_to_base_transform_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_point_pose pending_pts[$];
    t_base_pt    expected_pts[$];
    longint      regs[6];
    int          err_cnt = 0;
    int          chk_cnt = 0;
    int          cfg_cnt = 0;
    int          cycle_cnt = 0;
    bit          no_idle = 0;
    bit          in_took = 0;
    bit          out_took = 0;
    int          in_gap = 0;
    int          out_stall = 0;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint quarter_sine(longint r);
        longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned x, x2, t;
        x  = (longint'(r) * 64'd18740330 + 64'd32768) >> 16;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 30) - ((((x2 / divs[i]) * t) + (64'd1 << 29)) >> 30);
        t = (x * t + (64'd1 << 29)) >> 30;
        return longint'((t + (64'd1 << 13)) >> 14);
    endfunction

    task automatic angle_sincos(input longint a, output longint s, output longint c);
        longint m, q, r, sr, cr;
        m = a % ANG_FULL;
        if (m < 0) m += ANG_FULL;
        q = m / ANG_QUAD;
        r = m - q * ANG_QUAD;
        sr = quarter_sine(r);
        cr = quarter_sine(ANG_QUAD - r);
        case (q)
            0: begin s = sr;  c = cr;  end
            1: begin s = cr;  c = -sr; end
            2: begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr; end
        endcase
    endtask

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic transform_point(input t_point_pose p, output t_base_pt b);
        longint rot[3][2] = '{'{5892, -50482}, '{64448, 1750}, '{4594, 35861}};
        longint fl[3], m[3][3], row[3];
        longint sa, ca, sb, cb, sc, cc, acc;
        angle_sincos(longint'(p.rz), sc, cc);
        angle_sincos(longint'(p.ry), sb, cb);
        angle_sincos(longint'(p.rx), sa, ca);
        for (int i = 0; i < 3; i++)
            fl[i] = rnd_shift(rot[i][0] * longint'(p.lx) + rot[i][1] * longint'(p.lz), 16)
                    + regs[i];
        m[0][0] = rnd_shift(ca * cb, 16);
        m[0][1] = rnd_shift(ca * sb * sc - sa * cc * 65536, 32);
        m[0][2] = rnd_shift(ca * sb * cc + sa * sc * 65536, 32);
        m[1][0] = rnd_shift(sa * cb, 16);
        m[1][1] = rnd_shift(sa * sb * sc + ca * cc * 65536, 32);
        m[1][2] = rnd_shift(sa * sb * cc - ca * sc * 65536, 32);
        m[2][0] = -sb;
        m[2][1] = rnd_shift(cb * sc, 16);
        m[2][2] = rnd_shift(cb * cc, 16);
        for (int i = 0; i < 3; i++) begin
            acc = m[i][0] * fl[0] + m[i][1] * fl[1] + m[i][2] * fl[2];
            row[i] = rnd_shift(acc, 16);
        end
        b.bx = clip32(row[0] + longint'(p.px) + regs[3]);
        b.by = clip32(row[1] + longint'(p.py) + regs[4]);
        b.bz = clip32(row[2] + longint'(p.pz) + regs[5]);
    endtask

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // input driver
    always @(negedge i_clk) begin
        logic nv;
        t_point_pose cur;
        nv = in_ch.valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!in_ch.valid || in_took) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_pts.size() > 0) begin
                cur = pending_pts.pop_front();
                nv = 1'b1;
                in_ch.laser_x <= cur.lx;
                in_ch.laser_z <= cur.lz;
                in_ch.pose_x  <= cur.px;
                in_ch.pose_y  <= cur.py;
                in_ch.pose_z  <= cur.pz;
                in_ch.pose_rz <= cur.rz;
                in_ch.pose_ry <= cur.ry;
                in_ch.pose_rx <= cur.rx;
                in_gap = draw_wait();
            end
        end
        in_ch.valid <= nv;
    end

    // result ready with random stalls
    always @(negedge i_clk) begin
        logic nr;
        if (out_took) out_stall = draw_wait();
        if (out_stall > 0) begin
            out_stall--;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        out_ch.ready <= nr;
    end

    // monitor
    always @(posedge i_clk) begin
        t_point_pose p;
        t_base_pt b, e;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
        in_took  <= in_ch.valid && in_ch.ready && i_rst_n;
        out_took <= out_ch.valid && out_ch.ready && i_rst_n;
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready
                && cfg_ch.index <= ltb_pkg::CFG_CORRECTION_Z)
            regs[cfg_ch.index] = longint'($signed(cfg_ch.data));
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            p.lx = in_ch.laser_x; p.lz = in_ch.laser_z;
            p.px = in_ch.pose_x;  p.py = in_ch.pose_y;  p.pz = in_ch.pose_z;
            p.rz = in_ch.pose_rz; p.ry = in_ch.pose_ry; p.rx = in_ch.pose_rx;
            transform_point(p, b);
            expected_pts.push_back(b);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_pts.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result beat %h %h %h",
                             out_ch.base_x, out_ch.base_y, out_ch.base_z);
            end else begin
                e = expected_pts.pop_front();
                chk_cnt++;
                if (out_ch.base_x !== e.bx || out_ch.base_y !== e.by
                        || out_ch.base_z !== e.bz) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch beat %0d: exp %h %h %h got %h %h %h", chk_cnt,
                                 e.bx, e.by, e.bz,
                                 out_ch.base_x, out_ch.base_y, out_ch.base_z);
                end
            end
        end
    end

    task automatic write_reg(input logic [ltb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_cnt++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pts.size() > 0 || in_ch.valid || expected_pts.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    function automatic logic signed [25:0] rand_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 26'(($urandom_range(0, 8) - 4) * ANG_QUAD + $urandom_range(0, 2) - 1);
        return 26'($urandom_range(0, 2 * ANG_FULL) - ANG_FULL);
    endfunction

    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
    endfunction

    function automatic t_point_pose rand_point();
        t_point_pose p;
        p.lx = rand_pos(); p.lz = rand_pos();
        p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
        p.rz = rand_angle(); p.ry = rand_angle(); p.rx = rand_angle();
        return p;
    endfunction

    function automatic t_point_pose mk(logic signed [31:0] l, logic signed [31:0] q,
                                       logic signed [25:0] a);
        t_point_pose p;
        p.lx = l; p.lz = l; p.px = q; p.py = q; p.pz = q;
        p.rz = a; p.ry = a; p.rx = a;
        return p;
    endfunction

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) pending_pts.push_back(rand_point());
    endtask

    initial begin
        t_point_pose p;
        in_ch.valid = 1'b0;
        in_ch.laser_x = '0; in_ch.laser_z = '0;
        in_ch.pose_x = '0; in_ch.pose_y = '0; in_ch.pose_z = '0;
        in_ch.pose_rz = '0; in_ch.pose_ry = '0; in_ch.pose_rx = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        regs = '{3076758, -127428, 23021689, 0, 0, 0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, quadrant boundaries, wrapped angles
        pending_pts.push_back(mk(32'sd0, 32'sd0, 26'sd0));
        pending_pts.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 26'sd0));
        pending_pts.push_back(mk(32'sh80000000, 32'sh80000000, 26'sd0));
        pending_pts.push_back(mk(32'sh7fffffff, 32'sh80000000, 26'sd23592960));
        pending_pts.push_back(mk(32'sh80000000, 32'sh7fffffff, -26'sd23592960));
        for (int k = -4; k <= 4; k++)
            pending_pts.push_back(mk(32'sd655360, 32'sd6553600, 26'(k * ANG_QUAD)));
        pending_pts.push_back(mk(32'sd655360, 32'sd0, 26'sd2949120));
        pending_pts.push_back(mk(-32'sd655360, 32'sd0, 26'sd5898239));
        pending_pts.push_back(mk(-32'sd655360, 32'sd0, -26'sd1));
        p = mk(32'sd1000000, -32'sd3000000, 26'sd0);
        p.rz = 26'sd5898240; p.ry = -26'sd11796480; p.rx = 26'sd23592959;
        pending_pts.push_back(p);
        p.lx = 32'sh80000000; p.lz = 32'sh7fffffff;
        p.rz = -26'sd23592959; p.ry = 26'sd1; p.rx = 26'sd17694720;
        pending_pts.push_back(p);
        no_idle = 1;
        drain();
        no_idle = 0;

        push_random(150);
        drain();
        push_random(120);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: for (int r = 0; r < 6; r++) write_reg(3'(r), 32'h7fffffff);
                1: for (int r = 0; r < 6; r++) write_reg(3'(r), 32'h80000000);
                2: for (int r = 0; r < 6; r++) write_reg(3'(r), 32'h0);
                default: begin
                    write_reg(ltb_pkg::CFG_LASER_OFFSET_X, rand_pos());
                    write_reg(ltb_pkg::CFG_LASER_OFFSET_Y, rand_pos());
                    write_reg(ltb_pkg::CFG_LASER_OFFSET_Z, rand_pos());
                    write_reg(ltb_pkg::CFG_CORRECTION_X, rand_pos());
                    write_reg(ltb_pkg::CFG_CORRECTION_Y, rand_pos());
                    write_reg(ltb_pkg::CFG_CORRECTION_Z, rand_pos());
                    write_reg(CFG_SPARE_6, $urandom);
                    write_reg(CFG_SPARE_7, $urandom);
                end
            endcase
            no_idle = (ph == 2);
            push_random(ph < 3 ? 100 : 230);
            drain();
        end

        $display("checked %0d result beats over %0d register writes,", chk_cnt, cfg_cnt);
        $display("covering reset, extreme, zero and random offset settings");
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
